/* hdl/bisp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bisp_pkg
// Shared types and constants for the index stream parser: record kinds,
// error codes, register indexes and the record carried through the queue.
// ----------------------------------------------------------------------------
package bisp_pkg;

  // stream widths
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned KIND_W     = 3;
  localparam int unsigned REF_W      = 31;
  localparam int unsigned BIN_W      = 32;
  localparam int unsigned COUNT_W    = 31;
  localparam int unsigned OFFSET_W   = 64;
  localparam int unsigned ERR_W      = 3;
  localparam int unsigned OUT_DATA_W = 232;

  // configuration port
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam logic [CFG_INDEX_W-1:0] CFG_SKIP_ENABLE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SKIP_NUMBER = 2'd1;

  // reset values and file constants
  localparam logic [31:0] MAGIC_WORD      = 32'h0149_4142;
  localparam logic [31:0] SKIP_BIN_RESET  = 32'd37450;
  localparam int unsigned FIFO_DEPTH      = 4;

  // record kinds
  localparam logic [KIND_W-1:0] KIND_BIN_HEADER = 3'd0;
  localparam logic [KIND_W-1:0] KIND_CHUNK      = 3'd1;
  localparam logic [KIND_W-1:0] KIND_INTERVAL   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_REF_DONE   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_INDEX_DONE = 3'd4;
  localparam logic [KIND_W-1:0] KIND_ERROR      = 3'd5;

  // error codes
  localparam logic [ERR_W-1:0] ERR_NONE      = 3'd0;
  localparam logic [ERR_W-1:0] ERR_MAGIC     = 3'd1;
  localparam logic [ERR_W-1:0] ERR_REFS      = 3'd2;
  localparam logic [ERR_W-1:0] ERR_BINS      = 3'd3;
  localparam logic [ERR_W-1:0] ERR_CHUNKS    = 3'd4;
  localparam logic [ERR_W-1:0] ERR_INTERVALS = 3'd5;
  localparam logic [ERR_W-1:0] ERR_EARLY_END = 3'd6;

  // compact record between parser and emitter
  // word_a holds the chunk count or the first offset, word_b the chunk end
  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [REF_W-1:0]    ref_num;
    logic [BIN_W-1:0]    bin_num;
    logic [OFFSET_W-1:0] word_a;
    logic [OFFSET_W-1:0] word_b;
    logic                flag;
    logic [ERR_W-1:0]    err;
  } record_t;

endpackage

/* hdl/bisp_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bisp_parser
// Front end: takes one byte beat per cycle, assembles little-endian fields,
// walks the nested counts and produces at most one compact record per beat.
// ----------------------------------------------------------------------------
module bisp_parser (
  input  logic                                clk,
  input  logic                                rst,
  // configuration writes
  input  logic                                cfg_we,
  input  logic [bisp_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [bisp_pkg::CFG_DATA_W-1:0]     cfg_data,
  // byte beats
  input  logic                                beat,
  input  logic [bisp_pkg::BYTE_W-1:0]         data_byte,
  input  logic                                end_of_file,
  // record out
  output logic                                rec_valid,
  output bisp_pkg::record_t                   rec
);

  typedef enum logic [3:0] {
    PH_MAGIC, PH_NREF, PH_NBIN, PH_BIN, PH_NCHUNK,
    PH_CBEG, PH_CEND, PH_NINTV, PH_INTV, PH_DONE, PH_ERROR
  } phase_t;

  phase_t                          phase, phase_next;
  logic [2:0]                      pos, pos_next;
  logic [63:0]                     acc, acc_next;
  logic [30:0]                     refs_left, refs_left_next;
  logic [30:0]                     cur_ref, cur_ref_next;
  logic [30:0]                     bins_left, bins_left_next;
  logic [31:0]                     cur_bin, cur_bin_next;
  logic [30:0]                     chunks_left, chunks_left_next;
  logic [30:0]                     intervals_left, intervals_left_next;
  logic [63:0]                     chunk_start, chunk_start_next;
  logic                            skipping, skipping_next;
  logic                            pending, pending_next;
  logic [bisp_pkg::ERR_W-1:0]      err, err_next;
  logic                            skip_enable;
  logic [31:0]                     skip_number;

  logic [63:0]                     value;
  logic [31:0]                     word;
  logic                            last_byte;
  logic [30:0]                     bins_dec, refs_dec, chunks_dec, intervals_dec;

  // field assembly: current byte placed at its lane
  always_comb begin
    value     = acc | ({56'd0, data_byte} << {pos, 3'b000});
    word      = value[31:0];
    last_byte = (phase == PH_CBEG || phase == PH_CEND || phase == PH_INTV) ?
                (pos == 3'd7) : (pos == 3'd3);
    bins_dec      = bins_left - 31'd1;
    refs_dec      = refs_left - 31'd1;
    chunks_dec    = chunks_left - 31'd1;
    intervals_dec = intervals_left - 31'd1;
  end

  // per-beat parse step
  always_comb begin
    phase_next          = phase;
    pos_next            = pos;
    acc_next            = acc;
    refs_left_next      = refs_left;
    cur_ref_next        = cur_ref;
    bins_left_next      = bins_left;
    cur_bin_next        = cur_bin;
    chunks_left_next    = chunks_left;
    intervals_left_next = intervals_left;
    chunk_start_next    = chunk_start;
    skipping_next       = skipping;
    pending_next        = pending;
    err_next            = err;
    rec_valid           = 1'b0;
    rec                 = '0;
    rec.ref_num         = cur_ref;

    if (beat) begin
      if (phase == PH_ERROR) begin
        rec_valid = 1'b1;
        rec.kind  = bisp_pkg::KIND_ERROR;
        rec.err   = err;
      end else if (pending) begin
        // deferred reference done after the last interval
        pending_next = 1'b0;
        rec_valid    = 1'b1;
        rec.kind     = bisp_pkg::KIND_REF_DONE;
        rec.flag     = (refs_left == 31'd0);
        cur_ref_next = cur_ref + 31'd1;
        if (phase != PH_DONE) begin
          if (end_of_file) begin
            phase_next = PH_ERROR;
            err_next   = bisp_pkg::ERR_EARLY_END;
          end else begin
            acc_next = value;
            pos_next = pos + 3'd1;
          end
        end
      end else if (phase == PH_DONE) begin
        if (end_of_file) begin
          rec_valid = 1'b1;
          rec.kind  = bisp_pkg::KIND_INDEX_DONE;
          rec.flag  = 1'b1;
        end
      end else if (end_of_file) begin
        rec_valid  = 1'b1;
        rec.kind   = bisp_pkg::KIND_ERROR;
        rec.err    = bisp_pkg::ERR_EARLY_END;
        phase_next = PH_ERROR;
        err_next   = bisp_pkg::ERR_EARLY_END;
      end else if (!last_byte) begin
        acc_next = value;
        pos_next = pos + 3'd1;
      end else begin
        // field complete
        acc_next = '0;
        pos_next = '0;
        case (phase)
          PH_MAGIC: begin
            if (word != bisp_pkg::MAGIC_WORD) begin
              rec_valid  = 1'b1;
              rec.kind   = bisp_pkg::KIND_ERROR;
              rec.err    = bisp_pkg::ERR_MAGIC;
              phase_next = PH_ERROR;
              err_next   = bisp_pkg::ERR_MAGIC;
            end else begin
              phase_next = PH_NREF;
            end
          end
          PH_NREF: begin
            if (word[31]) begin
              rec_valid  = 1'b1;
              rec.kind   = bisp_pkg::KIND_ERROR;
              rec.err    = bisp_pkg::ERR_REFS;
              phase_next = PH_ERROR;
              err_next   = bisp_pkg::ERR_REFS;
            end else begin
              refs_left_next = word[30:0];
              phase_next     = (word[30:0] != 31'd0) ? PH_NBIN : PH_DONE;
            end
          end
          PH_NBIN: begin
            if (word[31]) begin
              rec_valid  = 1'b1;
              rec.kind   = bisp_pkg::KIND_ERROR;
              rec.err    = bisp_pkg::ERR_BINS;
              phase_next = PH_ERROR;
              err_next   = bisp_pkg::ERR_BINS;
            end else begin
              bins_left_next = word[30:0];
              phase_next     = (word[30:0] != 31'd0) ? PH_BIN : PH_NINTV;
            end
          end
          PH_BIN: begin
            cur_bin_next  = word;
            skipping_next = skip_enable && (word == skip_number);
            phase_next    = PH_NCHUNK;
          end
          PH_NCHUNK: begin
            if (word[31]) begin
              rec_valid  = 1'b1;
              rec.kind   = bisp_pkg::KIND_ERROR;
              rec.err    = bisp_pkg::ERR_CHUNKS;
              phase_next = PH_ERROR;
              err_next   = bisp_pkg::ERR_CHUNKS;
            end else begin
              chunks_left_next = word[30:0];
              if (word[30:0] != 31'd0) begin
                phase_next = PH_CBEG;
              end else begin
                bins_left_next = bins_dec;
                phase_next     = (bins_dec != 31'd0) ? PH_BIN : PH_NINTV;
              end
              if (!skipping) begin
                rec_valid   = 1'b1;
                rec.kind    = bisp_pkg::KIND_BIN_HEADER;
                rec.bin_num = cur_bin;
                rec.word_a  = {33'd0, word[30:0]};
              end
            end
          end
          PH_CBEG: begin
            chunk_start_next = value;
            phase_next       = PH_CEND;
          end
          PH_CEND: begin
            chunks_left_next = chunks_dec;
            if (chunks_dec != 31'd0) begin
              phase_next = PH_CBEG;
            end else begin
              bins_left_next = bins_dec;
              phase_next     = (bins_dec != 31'd0) ? PH_BIN : PH_NINTV;
            end
            if (!skipping) begin
              rec_valid   = 1'b1;
              rec.kind    = bisp_pkg::KIND_CHUNK;
              rec.bin_num = cur_bin;
              rec.word_a  = chunk_start;
              rec.word_b  = value;
            end
          end
          PH_NINTV: begin
            if (word[31]) begin
              rec_valid  = 1'b1;
              rec.kind   = bisp_pkg::KIND_ERROR;
              rec.err    = bisp_pkg::ERR_INTERVALS;
              phase_next = PH_ERROR;
              err_next   = bisp_pkg::ERR_INTERVALS;
            end else begin
              intervals_left_next = word[30:0];
              if (word[30:0] != 31'd0) begin
                phase_next = PH_INTV;
              end else begin
                // empty interval list closes the reference at once
                refs_left_next = refs_dec;
                phase_next     = (refs_dec != 31'd0) ? PH_NBIN : PH_DONE;
                rec_valid      = 1'b1;
                rec.kind       = bisp_pkg::KIND_REF_DONE;
                rec.flag       = (refs_dec == 31'd0);
                cur_ref_next   = cur_ref + 31'd1;
              end
            end
          end
          PH_INTV: begin
            rec_valid           = 1'b1;
            rec.kind            = bisp_pkg::KIND_INTERVAL;
            rec.word_a          = value;
            intervals_left_next = intervals_dec;
            if (intervals_dec == 31'd0) begin
              refs_left_next = refs_dec;
              phase_next     = (refs_dec != 31'd0) ? PH_NBIN : PH_DONE;
              pending_next   = 1'b1;
            end
          end
          default: begin
            rec_valid  = 1'b1;
            rec.kind   = bisp_pkg::KIND_ERROR;
            rec.err    = bisp_pkg::ERR_EARLY_END;
            phase_next = PH_ERROR;
            err_next   = bisp_pkg::ERR_EARLY_END;
          end
        endcase
      end
    end
  end

  // parser state and configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_MAGIC;
      pos            <= '0;
      acc            <= '0;
      refs_left      <= '0;
      cur_ref        <= '0;
      bins_left      <= '0;
      cur_bin        <= '0;
      chunks_left    <= '0;
      intervals_left <= '0;
      chunk_start    <= '0;
      skipping       <= 1'b0;
      pending        <= 1'b0;
      err            <= bisp_pkg::ERR_NONE;
      skip_enable    <= 1'b1;
      skip_number    <= bisp_pkg::SKIP_BIN_RESET;
    end else begin
      phase          <= phase_next;
      pos            <= pos_next;
      acc            <= acc_next;
      refs_left      <= refs_left_next;
      cur_ref        <= cur_ref_next;
      bins_left      <= bins_left_next;
      cur_bin        <= cur_bin_next;
      chunks_left    <= chunks_left_next;
      intervals_left <= intervals_left_next;
      chunk_start    <= chunk_start_next;
      skipping       <= skipping_next;
      pending        <= pending_next;
      err            <= err_next;
      if (cfg_we) begin
        if (cfg_index == bisp_pkg::CFG_SKIP_ENABLE) begin
          skip_enable <= cfg_data[0];
        end else if (cfg_index == bisp_pkg::CFG_SKIP_NUMBER) begin
          skip_number <= cfg_data;
        end
      end
    end
  end

endmodule

/* hdl/bisp_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bisp_fifo
// Short record queue between the parser and the emitter, with push and pop
// allowed in the same cycle.
// ----------------------------------------------------------------------------
module bisp_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             not_empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == FULL_CNT);
  assign not_empty = (count != '0);
  assign pop_data  = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

/* hdl/bisp_emitter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bisp_emitter
// Back end: pops compact records, expands them into the result fields of
// their kind and holds them in the output register until taken.
// ----------------------------------------------------------------------------
module bisp_emitter (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                rec_valid,
  input  bisp_pkg::record_t                   rec,
  output logic                                rec_pop,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [bisp_pkg::KIND_W-1:0]         m_tuser,
  output logic [bisp_pkg::OUT_DATA_W-1:0]     m_tdata
);

  logic [bisp_pkg::COUNT_W-1:0]  item_count;
  logic [bisp_pkg::OFFSET_W-1:0] first_offset;
  logic [bisp_pkg::OFFSET_W-1:0] second_offset;
  logic [bisp_pkg::BIN_W-1:0]    bin_number;
  logic [bisp_pkg::OUT_DATA_W-1:0] data_next;

  assign rec_pop = rec_valid && (!m_tvalid || m_tready);

  // expand by kind
  always_comb begin
    item_count    = '0;
    first_offset  = '0;
    second_offset = '0;
    bin_number    = '0;
    case (rec.kind)
      bisp_pkg::KIND_BIN_HEADER: begin
        bin_number = rec.bin_num;
        item_count = rec.word_a[bisp_pkg::COUNT_W-1:0];
      end
      bisp_pkg::KIND_CHUNK: begin
        bin_number    = rec.bin_num;
        first_offset  = rec.word_a;
        second_offset = rec.word_b;
      end
      bisp_pkg::KIND_INTERVAL: begin
        first_offset = rec.word_a;
      end
      default: begin
        item_count = '0;
      end
    endcase
    data_next = {6'd0, rec.err, rec.flag, second_offset, first_offset,
                 item_count, bin_number, rec.ref_num};
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (rec_pop) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rec_pop) begin
      m_tuser <= rec.kind;
      m_tdata <= data_next;
    end
  end

endmodule

/* hdl/bam_index_stream_parser_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bam_index_stream_parser_core
// Parses a BAM index byte stream into bin, chunk, interval and completion
// records, with a sticky error record after the first fault.
// ----------------------------------------------------------------------------
// Throughput: one byte beat per cycle; the parser state updates once a beat.
// Records: each is queued at the edge that accepts its beat, then loaded into
//   the output register when the emitter pops it from the queue.
// Input stalls only when the record queue is full (FIFO_DEPTH records).
// Reset: synchronous; clears parse state, queue and output valid, and sets
//   the skip registers to enabled and bin 37450.
module bam_index_stream_parser_core #(
  parameter int unsigned FIFO_DEPTH = bisp_pkg::FIFO_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration
  input  logic                                cfg_we,
  input  logic [bisp_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [bisp_pkg::CFG_DATA_W-1:0]     cfg_data,
  // byte input
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [bisp_pkg::BYTE_W-1:0]         s_tdata,   // [7:0] data_byte
  input  logic                                s_tlast,   // end_of_file
  // record output
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [bisp_pkg::KIND_W-1:0]         m_tuser,   // [2:0] record_kind
  // [30:0] reference_number, [62:31] bin_number, [93:63] item_count,
  // [157:94] first_offset, [221:158] second_offset, [222] index_complete,
  // [225:223] error_code, [231:226] zero
  output logic [bisp_pkg::OUT_DATA_W-1:0]     m_tdata
);

  logic              beat;
  logic              fifo_full;
  logic              rec_valid;
  bisp_pkg::record_t rec_in;
  bisp_pkg::record_t rec_out;
  logic              rec_avail;
  logic              rec_pop;

  assign s_tready = !fifo_full;
  assign beat     = s_tvalid && s_tready;

  // front: byte assembly and structure walk
  bisp_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .beat        (beat),
    .data_byte   (s_tdata),
    .end_of_file (s_tlast),
    .rec_valid   (rec_valid),
    .rec         (rec_in)
  );

  // record queue
  bisp_fifo #(
    .WIDTH ($bits(bisp_pkg::record_t)),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (rec_valid),
    .push_data (rec_in),
    .full      (fifo_full),
    .pop       (rec_pop),
    .pop_data  (rec_out),
    .not_empty (rec_avail)
  );

  // back: record expansion and output register
  bisp_emitter u_emitter (
    .clk       (clk),
    .rst       (rst),
    .rec_valid (rec_avail),
    .rec       (rec_out),
    .rec_pop   (rec_pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tuser   (m_tuser),
    .m_tdata   (m_tdata)
  );

endmodule

/* bench/tb_bam_index_stream_parser_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bam_index_stream_parser_core
// Feeds one index file byte by byte with random gaps on both sides. The file
// has a fixed opening, then random references, and ends either complete or
// with one randomly chosen fault. Skip settings change between references.
// Each byte beat is run through a local parser copy, and every record beat
// is compared field by field with the oldest predicted record.
// ----------------------------------------------------------------------------
module tb_bam_index_stream_parser_core;

  localparam int HALF_PERIOD   = 2;
  localparam int RESET_CYCLES  = 5;
  localparam int IDLE_PCT      = 16;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_AT_BEAT  = 150;
  localparam int HOLD_CYCLES   = 300;
  localparam int CALM_FROM     = 60;
  localparam int CALM_TO       = 140;
  localparam int DRAIN_CYCLES  = 20;
  localparam int STALL_LIMIT   = 4000;

  // indexes with no register behind them
  localparam logic [bisp_pkg::CFG_INDEX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [bisp_pkg::CFG_INDEX_W-1:0] CFG_SPARE_3 = 2'd3;

  // file endings picked per run
  localparam int END_BAD_MAGIC    = 0;
  localparam int END_NEG_REFS     = 1;
  localparam int END_NEG_BINS     = 2;
  localparam int END_NEG_CHUNKS   = 3;
  localparam int END_NEG_INTERVAL = 4;
  localparam int END_EOF_IN_FIELD = 5;
  localparam int END_EOF_AT_FIELD = 6;
  localparam int END_EOF_OWED     = 7;
  localparam int END_COMPLETE     = 8;
  localparam int END_NO_REFS      = 12;

  typedef enum logic [3:0] {
    AT_MAGIC, AT_REF_COUNT, AT_BIN_COUNT, AT_BIN_NUMBER, AT_CHUNK_COUNT,
    AT_CHUNK_BEGIN, AT_CHUNK_END, AT_INTERVAL_COUNT, AT_INTERVAL,
    AT_COMPLETE, AT_FAULT
  } walk_phase_t;

  typedef struct packed {
    logic [bisp_pkg::KIND_W-1:0]   kind;
    logic [bisp_pkg::REF_W-1:0]    ref_num;
    logic [bisp_pkg::BIN_W-1:0]    bin_num;
    logic [bisp_pkg::COUNT_W-1:0]  count;
    logic [bisp_pkg::OFFSET_W-1:0] off_a;
    logic [bisp_pkg::OFFSET_W-1:0] off_b;
    logic                          flag;
    logic [bisp_pkg::ERR_W-1:0]    err;
  } index_rec_t;

  typedef struct {
    bit                               is_cfg;
    logic [bisp_pkg::BYTE_W-1:0]      data;
    logic                             last;
    logic [bisp_pkg::CFG_INDEX_W-1:0] idx;
    logic [bisp_pkg::CFG_DATA_W-1:0]  val;
  } file_item_t;

  logic                               clk = 1'b0;
  logic                               rst = 1'b1;
  logic                               cfg_we = 1'b0;
  logic [bisp_pkg::CFG_INDEX_W-1:0]   cfg_index = '0;
  logic [bisp_pkg::CFG_DATA_W-1:0]    cfg_data = '0;
  logic                               s_tvalid = 1'b0;
  logic                               s_tready;
  logic [bisp_pkg::BYTE_W-1:0]        s_tdata = '0;
  logic                               s_tlast = 1'b0;
  logic                               m_tvalid;
  logic                               m_tready = 1'b0;
  logic [bisp_pkg::KIND_W-1:0]        m_tuser;
  logic [bisp_pkg::OUT_DATA_W-1:0]    m_tdata;

  bam_index_stream_parser_core u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tuser  (m_tuser),
    .m_tdata  (m_tdata)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // bench bookkeeping
  file_item_t  file_q[$];
  index_rec_t  records_due[$];
  int          mismatches = 0;
  int          results_seen = 0;
  int          beats_in = 0;
  bit          beat_taken = 1'b0;
  int          settle_cnt = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;
  int          stall_cycles = 0;
  logic [31:0] gen_skip_num;

  // local parser state
  walk_phase_t                walk_phase;
  logic [2:0]                 byte_idx;
  logic [63:0]                field_acc;
  logic [31:0]                refs_left;
  logic [30:0]                ref_idx;
  logic [31:0]                bins_left;
  logic [31:0]                bin_num;
  logic [31:0]                chunks_left;
  logic [31:0]                intervals_left;
  logic [63:0]                chunk_begin;
  logic                       in_skipped_bin;
  logic                       ref_done_owed;
  logic [bisp_pkg::ERR_W-1:0] stuck_code;
  logic                       skip_enable;
  logic [31:0]                skip_number;

  function automatic void parser_reset();
    walk_phase     = AT_MAGIC;
    byte_idx       = '0;
    field_acc      = '0;
    refs_left      = '0;
    ref_idx        = '0;
    bins_left      = '0;
    bin_num        = '0;
    chunks_left    = '0;
    intervals_left = '0;
    chunk_begin    = '0;
    in_skipped_bin = 1'b0;
    ref_done_owed  = 1'b0;
    stuck_code     = bisp_pkg::ERR_NONE;
    skip_enable    = 1'b1;
    skip_number    = bisp_pkg::SKIP_BIN_RESET;
  endfunction

  // little-endian field assembly; offsets are 8 bytes, counts 4
  function automatic bit field_done(input logic [7:0] b, output logic [63:0] value);
    int len;
    value = '0;
    field_acc = field_acc | ({56'd0, b} << (8 * byte_idx));
    len = (walk_phase == AT_CHUNK_BEGIN || walk_phase == AT_CHUNK_END ||
           walk_phase == AT_INTERVAL) ? 8 : 4;
    if (int'(byte_idx) + 1 < len) begin
      byte_idx = byte_idx + 3'd1;
      return 1'b0;
    end
    value     = field_acc;
    field_acc = '0;
    byte_idx  = '0;
    return 1'b1;
  endfunction

  function automatic index_rec_t blank_record(input logic [bisp_pkg::KIND_W-1:0] kind);
    index_rec_t r;
    r         = '0;
    r.kind    = kind;
    r.ref_num = ref_idx;
    return r;
  endfunction

  function automatic index_rec_t ref_done_record();
    index_rec_t r;
    r       = blank_record(bisp_pkg::KIND_REF_DONE);
    r.flag  = (refs_left == 0);
    ref_idx = ref_idx + 31'd1;
    return r;
  endfunction

  function automatic index_rec_t fault_record(input logic [bisp_pkg::ERR_W-1:0] code);
    index_rec_t r;
    walk_phase = AT_FAULT;
    stuck_code = code;
    r          = blank_record(bisp_pkg::KIND_ERROR);
    r.err      = code;
    return r;
  endfunction

  function automatic void close_bin();
    bins_left  = bins_left - 32'd1;
    walk_phase = (bins_left != 0) ? AT_BIN_NUMBER : AT_INTERVAL_COUNT;
  endfunction

  function automatic void close_ref();
    refs_left  = refs_left - 32'd1;
    walk_phase = (refs_left != 0) ? AT_BIN_COUNT : AT_COMPLETE;
  endfunction

  // one byte beat in, at most one record out
  function automatic bit predict_record(input logic [7:0] b, input logic eof,
                                        output index_rec_t r);
    logic [63:0] value;
    logic [31:0] w;
    r = '0;
    if (walk_phase == AT_FAULT) begin
      r     = blank_record(bisp_pkg::KIND_ERROR);
      r.err = stuck_code;
      return 1'b1;
    end
    // reference done owed after the last interval, whatever the beat is
    if (ref_done_owed) begin
      ref_done_owed = 1'b0;
      r = ref_done_record();
      if (walk_phase != AT_COMPLETE) begin
        if (eof) begin
          walk_phase = AT_FAULT;
          stuck_code = bisp_pkg::ERR_EARLY_END;
        end else begin
          void'(field_done(b, value));
        end
      end
      return 1'b1;
    end
    if (walk_phase == AT_COMPLETE) begin
      if (!eof) return 1'b0;
      r      = blank_record(bisp_pkg::KIND_INDEX_DONE);
      r.flag = 1'b1;
      return 1'b1;
    end
    if (eof) begin
      r = fault_record(bisp_pkg::ERR_EARLY_END);
      return 1'b1;
    end
    if (!field_done(b, value)) return 1'b0;
    w = value[31:0];
    case (walk_phase)
      AT_MAGIC: begin
        if (w != bisp_pkg::MAGIC_WORD) begin
          r = fault_record(bisp_pkg::ERR_MAGIC);
          return 1'b1;
        end
        walk_phase = AT_REF_COUNT;
        return 1'b0;
      end
      AT_REF_COUNT: begin
        if (w[31]) begin
          r = fault_record(bisp_pkg::ERR_REFS);
          return 1'b1;
        end
        refs_left  = w;
        walk_phase = (w != 0) ? AT_BIN_COUNT : AT_COMPLETE;
        return 1'b0;
      end
      AT_BIN_COUNT: begin
        if (w[31]) begin
          r = fault_record(bisp_pkg::ERR_BINS);
          return 1'b1;
        end
        bins_left  = w;
        walk_phase = (w != 0) ? AT_BIN_NUMBER : AT_INTERVAL_COUNT;
        return 1'b0;
      end
      AT_BIN_NUMBER: begin
        bin_num        = w;
        in_skipped_bin = skip_enable && (w == skip_number);
        walk_phase     = AT_CHUNK_COUNT;
        return 1'b0;
      end
      AT_CHUNK_COUNT: begin
        if (w[31]) begin
          r = fault_record(bisp_pkg::ERR_CHUNKS);
          return 1'b1;
        end
        chunks_left = w;
        if (w != 0) walk_phase = AT_CHUNK_BEGIN;
        else close_bin();
        if (in_skipped_bin) return 1'b0;
        r         = blank_record(bisp_pkg::KIND_BIN_HEADER);
        r.bin_num = bin_num;
        r.count   = w[30:0];
        return 1'b1;
      end
      AT_CHUNK_BEGIN: begin
        chunk_begin = value;
        walk_phase  = AT_CHUNK_END;
        return 1'b0;
      end
      AT_CHUNK_END: begin
        chunks_left = chunks_left - 32'd1;
        if (chunks_left != 0) walk_phase = AT_CHUNK_BEGIN;
        else close_bin();
        if (in_skipped_bin) return 1'b0;
        r         = blank_record(bisp_pkg::KIND_CHUNK);
        r.bin_num = bin_num;
        r.off_a   = chunk_begin;
        r.off_b   = value;
        return 1'b1;
      end
      AT_INTERVAL_COUNT: begin
        if (w[31]) begin
          r = fault_record(bisp_pkg::ERR_INTERVALS);
          return 1'b1;
        end
        intervals_left = w;
        if (w != 0) begin
          walk_phase = AT_INTERVAL;
          return 1'b0;
        end
        close_ref();
        r = ref_done_record();
        return 1'b1;
      end
      AT_INTERVAL: begin
        r              = blank_record(bisp_pkg::KIND_INTERVAL);
        r.off_a        = value;
        intervals_left = intervals_left - 32'd1;
        if (intervals_left == 0) begin
          close_ref();
          ref_done_owed = 1'b1;
        end
        return 1'b1;
      end
      default: begin
        r = fault_record(bisp_pkg::ERR_EARLY_END);
        return 1'b1;
      end
    endcase
  endfunction

  // file building
  task automatic add_byte(input logic [7:0] b, input logic last);
    file_item_t it;
    it.is_cfg = 1'b0;
    it.data   = b;
    it.last   = last;
    it.idx    = '0;
    it.val    = '0;
    file_q.push_back(it);
  endtask

  task automatic add_eof();
    add_byte(8'($urandom), 1'b1);
  endtask

  task automatic add_word(input logic [31:0] w);
    for (int i = 0; i < 4; i++) add_byte(w[8*i +: 8], 1'b0);
  endtask

  task automatic add_dword(input logic [63:0] v);
    for (int i = 0; i < 8; i++) add_byte(v[8*i +: 8], 1'b0);
  endtask

  task automatic add_cfg(input logic [bisp_pkg::CFG_INDEX_W-1:0] idx,
                         input logic [31:0] val);
    file_item_t it;
    it.is_cfg = 1'b1;
    it.data   = '0;
    it.last   = 1'b0;
    it.idx    = idx;
    it.val    = val;
    file_q.push_back(it);
    if (idx == bisp_pkg::CFG_SKIP_NUMBER) gen_skip_num = val;
  endtask

  function automatic logic [63:0] pick_offset();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // often the bin that is currently marked for skipping
  function automatic logic [31:0] pick_bin_number();
    case ($urandom_range(0, 11))
      0, 1:    return gen_skip_num;
      2:       return '0;
      3:       return '1;
      4:       return bisp_pkg::SKIP_BIN_RESET;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_bin(input logic [31:0] num, input int n_chunk);
    add_word(num);
    add_word(n_chunk);
    for (int i = 0; i < n_chunk; i++) begin
      add_dword(pick_offset());
      add_dword(pick_offset());
    end
  endtask

  task automatic add_random_ref();
    int n_bin;
    int n_chunk;
    int n_iv;
    n_bin = $urandom_range(0, 3);
    add_word(n_bin);
    for (int i = 0; i < n_bin; i++) begin
      n_chunk = ($urandom_range(0, 7) == 0) ? $urandom_range(3, 5) : $urandom_range(0, 2);
      add_bin(pick_bin_number(), n_chunk);
    end
    n_iv = $urandom_range(0, 3);
    add_word(n_iv);
    for (int i = 0; i < n_iv; i++) add_dword(pick_offset());
  endtask

  task automatic add_random_cfg();
    logic [31:0] num;
    case ($urandom_range(0, 3))
      0:       num = bisp_pkg::SKIP_BIN_RESET;
      1:       num = '0;
      2:       num = '1;
      default: num = $urandom;
    endcase
    add_cfg(bisp_pkg::CFG_SKIP_ENABLE, $urandom);
    add_cfg(bisp_pkg::CFG_SKIP_NUMBER, num);
    if ($urandom_range(0, 3) == 0)
      add_cfg($urandom_range(0, 1) ? CFG_SPARE_2 : CFG_SPARE_3, $urandom);
  endtask

  // bytes, end-of-file beats and register writes after the end of the walk
  task automatic add_tail(input int n, input int eof_pct);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < eof_pct) add_eof();
      else add_byte(8'($urandom), 1'b0);
      if (i % 100 == 99) add_random_cfg();
    end
  endtask

  function automatic bit quiet_stretch();
    return beats_in >= CALM_FROM && beats_in < CALM_TO;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want)
      report_mismatch($sformatf("record %0d %s: got %0h, want %0h",
                                results_seen, name, got, want));
  endtask

  // byte driver: holds a beat until taken, pauses for register writes
  always @(negedge clk) begin
    bit write_now;
    write_now = 1'b0;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!(s_tvalid && !beat_taken)) begin
      if (beat_taken) begin
        beat_taken = 1'b0;
        file_q.delete(0);
      end
      if (file_q.size() == 0) begin
        s_tvalid <= 1'b0;
      end else if (file_q[0].is_cfg) begin
        // write only once all records are in and the pipeline has settled
        s_tvalid <= 1'b0;
        if (records_due.size() == 0) settle_cnt++;
        else settle_cnt = 0;
        if (settle_cnt >= SETTLE_CYCLES) begin
          write_now = 1'b1;
          cfg_index <= file_q[0].idx;
          cfg_data  <= file_q[0].val;
          if (file_q[0].idx == bisp_pkg::CFG_SKIP_ENABLE) begin
            skip_enable = file_q[0].val[0];
          end else if (file_q[0].idx == bisp_pkg::CFG_SKIP_NUMBER) begin
            skip_number = file_q[0].val;
          end
          file_q.delete(0);
          settle_cnt = 0;
        end
      end else begin
        settle_cnt = 0;
        s_tvalid <= quiet_stretch() || ($urandom_range(0, 99) >= IDLE_PCT);
        s_tdata  <= file_q[0].data;
        s_tlast  <= file_q[0].last;
      end
    end
    cfg_we <= write_now;
  end

  // record receiver with one long hold-off
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (!hold_done && beats_in >= HOLD_AT_BEAT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= quiet_stretch() || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // monitor: check record beats, then predict from the byte beat
  always @(posedge clk) begin
    index_rec_t want;
    index_rec_t got;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        got.kind    = m_tuser;
        got.ref_num = m_tdata[30:0];
        got.bin_num = m_tdata[62:31];
        got.count   = m_tdata[93:63];
        got.off_a   = m_tdata[157:94];
        got.off_b   = m_tdata[221:158];
        got.flag    = m_tdata[222];
        got.err     = m_tdata[225:223];
        if (records_due.size() == 0) begin
          report_mismatch($sformatf("record %0d of kind %0d with none due",
                                    results_seen, got.kind));
        end else begin
          want = records_due.pop_front();
          check_field("record_kind", 64'(got.kind), 64'(want.kind));
          check_field("reference_number", 64'(got.ref_num), 64'(want.ref_num));
          check_field("bin_number", 64'(got.bin_num), 64'(want.bin_num));
          check_field("item_count", 64'(got.count), 64'(want.count));
          check_field("first_offset", got.off_a, want.off_a);
          check_field("second_offset", got.off_b, want.off_b);
          check_field("index_complete", 64'(got.flag), 64'(want.flag));
          check_field("error_code", 64'(got.err), 64'(want.err));
        end
      end
      if (s_tvalid && s_tready) begin
        beats_in++;
        beat_taken = 1'b1;
        if (predict_record(s_tdata, s_tlast, want)) records_due.push_back(want);
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: no beat for %0d cycles", STALL_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int ending;
    int extra_refs;
    int refs_total;
    logic [31:0] w;
    parser_reset();
    gen_skip_num = bisp_pkg::SKIP_BIN_RESET;
    ending       = $urandom_range(0, 12);
    extra_refs   = $urandom_range(3, 5);

    // opening writes: spare index, then the reset values again
    add_cfg(CFG_SPARE_2, $urandom);
    add_cfg(bisp_pkg::CFG_SKIP_NUMBER, bisp_pkg::SKIP_BIN_RESET);
    add_cfg(bisp_pkg::CFG_SKIP_ENABLE, 32'hFFFF_FFFF);

    if (ending == END_BAD_MAGIC) begin
      w = $urandom;
      if (w == bisp_pkg::MAGIC_WORD) w = w ^ 32'd1;
      add_word(w);
      add_tail(380, 25);
    end else if (ending == END_NEG_REFS) begin
      add_word(bisp_pkg::MAGIC_WORD);
      add_word(32'h8000_0000 | $urandom);
      add_tail(380, 25);
    end else if (ending == END_NO_REFS) begin
      // index complete at once; only end-of-file beats give records
      add_word(bisp_pkg::MAGIC_WORD);
      add_word(32'd0);
      add_tail(390, 50);
    end else begin
      refs_total = 2 + extra_refs;
      if (ending < END_COMPLETE) refs_total++;
      if (ending == END_EOF_OWED) refs_total++;
      add_word(bisp_pkg::MAGIC_WORD);
      add_word(refs_total);

      // skipped pseudo-bin, bin with no chunks, offset extremes, no intervals
      add_word(32'd3);
      add_word(bisp_pkg::SKIP_BIN_RESET);
      add_word(32'd1);
      add_dword('0);
      add_dword('1);
      add_bin('1, 0);
      add_word(32'd0);
      add_word(32'd1);
      add_dword('1);
      add_dword('0);
      add_word(32'd0);

      // skipping off: only bit 0 of the enable counts
      add_cfg(bisp_pkg::CFG_SKIP_ENABLE, 32'hFFFF_FFFE);
      add_cfg(bisp_pkg::CFG_SKIP_NUMBER, '1);
      add_cfg(CFG_SPARE_3, '1);

      // pseudo-bin shown, ends on an interval so reference done is owed
      add_word(32'd2);
      add_bin(bisp_pkg::SKIP_BIN_RESET, 1);
      add_bin('1, 0);
      add_word(32'd2);
      add_dword('1);
      add_dword('0);

      add_cfg(bisp_pkg::CFG_SKIP_ENABLE, 32'd1);
      add_cfg(bisp_pkg::CFG_SKIP_NUMBER, 32'd0);

      for (int i = 0; i < extra_refs; i++) begin
        add_random_ref();
        if ($urandom_range(0, 2) == 0) add_random_cfg();
      end

      // one faulty reference where the ending asks for it
      case (ending)
        END_NEG_BINS: add_word(32'h8000_0000 | $urandom);
        END_NEG_CHUNKS: begin
          add_word(32'd1);
          add_word(pick_bin_number());
          add_word(32'h8000_0000 | $urandom);
        end
        END_NEG_INTERVAL: begin
          add_word(32'd0);
          add_word(32'h8000_0000 | $urandom);
        end
        END_EOF_IN_FIELD: begin
          add_word(32'd1);
          add_word(pick_bin_number());
          add_word(32'h7FFF_FFFF);
          for (int i = $urandom_range(0, 7); i > 0; i--) add_byte(8'($urandom), 1'b0);
          add_eof();
        end
        END_EOF_AT_FIELD: begin
          add_word(32'd1);
          add_word(pick_bin_number());
          add_word(32'd0);
          add_eof();
        end
        END_EOF_OWED: begin
          add_word(32'd0);
          add_word(32'd1);
          add_dword(pick_offset());
          add_eof();
        end
        default: ;
      endcase
      add_tail((ending < END_COMPLETE) ? 40 : 24, 40);
    end

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    while (file_q.size() != 0 || s_tvalid || records_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("mismatches: %0d", mismatches);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
